@@ src/lrucc_pkg.sv @@
// Package for the LRU chunk read cache: sizes, derived widths and the
// controller/datapath interface types. No dependencies.
package lrucc_pkg;

  localparam int unsigned SLOT_COUNT        = 8;
  localparam int unsigned CHUNK_BYTES       = 4096;
  localparam int unsigned MAX_REQUEST_BYTES = 65536;
  localparam int unsigned MAX_SEGS          = 17;

  localparam int unsigned SLOT_W  = $clog2(SLOT_COUNT);
  localparam int unsigned OFF_W   = $clog2(CHUNK_BYTES);
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TAG_W   = ADDR_W - OFF_W;
  localparam int unsigned FILL_W  = OFF_W + 1;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned SEG_W   = $clog2(MAX_SEGS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

@@ src/lrucc_ctrl.sv @@
// Controller state machine of the LRU chunk read cache.
// Depends on lrucc_pkg; drives the datapath by command and reads its status.
module lrucc_ctrl import lrucc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/lrucc_datapath.sv @@
// Datapath of the LRU chunk read cache: request registers, slot tags and fill
// lengths, LRU order, segment arithmetic and the output register. Uses lrucc_pkg.
module lrucc_datapath import lrucc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               cfg_we_i,
  input  logic [ADDR_W-1:0]  cfg_wdata_i,
  input  logic [ADDR_W-1:0]  request_position_i,
  input  logic [COUNT_W-1:0] request_count_i,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               hit_o,
  output logic [ADDR_W-1:0]  chunk_base_o,
  output logic [OFF_W-1:0]   skip_o,
  output logic [FILL_W-1:0]  segment_length_o,
  output logic               short_read_o,
  output logic [COUNT_W-1:0] total_read_o,
  output logic               last_o
);

  logic [ADDR_W-1:0]  stream_len_q;
  logic [ADDR_W-1:0]  pos_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] total_q;
  logic [SEG_W-1:0]   nseg_q;

  logic [TAG_W-1:0]   tag_q   [SLOT_COUNT];
  logic [FILL_W-1:0]  fill_q  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  logic [SLOT_W-1:0]  lru_q   [SLOT_COUNT];
  logic [SLOT_W-1:0]  lru_d   [SLOT_COUNT];

  logic [SLOT_W-1:0]  slot_q;
  logic               hit_q;
  logic [ADDR_W-1:0]  base_q;
  logic [OFF_W-1:0]   skip_q;
  logic [FILL_W-1:0]  seg_q;
  logic               short_q;
  logic [COUNT_W-1:0] total_out_q;
  logic               last_q;

  logic [OFF_W-1:0]   off;
  logic [TAG_W-1:0]   tag;
  logic [ADDR_W-1:0]  base;
  logic [SLOT_COUNT-1:0] match;
  logic               hit;
  logic [SLOT_W-1:0]  hit_pos;
  logic [SLOT_W-1:0]  sel_slot;
  logic [ADDR_W-1:0]  rem;
  logic [FILL_W-1:0]  new_fill;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  got;
  logic [FILL_W-1:0]  room;
  logic [FILL_W-1:0]  wanted;
  logic [FILL_W-1:0]  seg;
  logic               is_short;
  logic [COUNT_W-1:0] count_nxt;
  logic               seg_last;
  logic               zero;
  logic [COUNT_W-1:0] count_sat;

  always_comb begin
    off  = pos_q[OFF_W-1:0];
    tag  = pos_q[ADDR_W-1:OFF_W];
    base = {tag, {OFF_W{1'b0}}};
    for (int p = 0; p < SLOT_COUNT; p++) begin
      match[p] = valid_q[lru_q[p]] && (tag_q[lru_q[p]] == tag);
    end
    hit     = 1'b0;
    hit_pos = SLOT_W'(SLOT_COUNT - 1);
    for (int p = 0; p < SLOT_COUNT; p++) begin
      if (match[p] && !hit) begin
        hit     = 1'b1;
        hit_pos = SLOT_W'(p);
      end
    end
    sel_slot = lru_q[hit_pos];

    rem = stream_len_q - base;
    if (base < stream_len_q) begin
      new_fill = (rem < ADDR_W'(CHUNK_BYTES)) ? rem[FILL_W-1:0] : FILL_W'(CHUNK_BYTES);
    end else begin
      new_fill = '0;
    end
    fill = hit ? fill_q[sel_slot] : new_fill;

    got    = (fill > {1'b0, off}) ? fill - {1'b0, off} : '0;
    room   = FILL_W'(CHUNK_BYTES) - {1'b0, off};
    wanted = (count_q < COUNT_W'(room)) ? count_q[FILL_W-1:0] : room;
    seg    = (wanted < got) ? wanted : got;
    is_short  = wanted > seg;
    count_nxt = count_q - COUNT_W'(seg);
    seg_last  = is_short || (count_nxt == '0) || (nseg_q == SEG_W'(MAX_SEGS - 1));
    zero      = count_q == '0;

    for (int q = 0; q < SLOT_COUNT; q++) begin
      if (q == 0) begin
        lru_d[q] = sel_slot;
      end else if (SLOT_W'(q) <= hit_pos) begin
        lru_d[q] = lru_q[q-1];
      end else begin
        lru_d[q] = lru_q[q];
      end
    end

    count_sat = (request_count_i > COUNT_W'(MAX_REQUEST_BYTES)) ?
                COUNT_W'(MAX_REQUEST_BYTES) : request_count_i;
  end

  assign sts_o.last = zero || seg_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= '0;
      valid_q      <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag_q[i]  <= '0;
        fill_q[i] <= '0;
        lru_q[i]  <= SLOT_W'(i);
      end
    end else begin
      if (cfg_we_i) begin
        stream_len_q <= cfg_wdata_i;
      end
      if (cmd_i.step && !zero) begin
        valid_q[sel_slot] <= 1'b1;
        tag_q[sel_slot]   <= tag;
        fill_q[sel_slot]  <= fill;
        lru_q             <= lru_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q   <= request_position_i;
      count_q <= count_sat;
      total_q <= '0;
      nseg_q  <= '0;
    end else if (cmd_i.step && !zero) begin
      pos_q   <= pos_q + ADDR_W'(seg);
      count_q <= count_nxt;
      total_q <= total_q + COUNT_W'(seg);
      nseg_q  <= nseg_q + SEG_W'(1);
    end
    if (cmd_i.step) begin
      base_q <= base;
      skip_q <= off;
      if (zero) begin
        slot_q      <= '0;
        hit_q       <= 1'b0;
        seg_q       <= '0;
        short_q     <= 1'b0;
        total_out_q <= '0;
        last_q      <= 1'b1;
      end else begin
        slot_q      <= sel_slot;
        hit_q       <= hit;
        seg_q       <= seg;
        short_q     <= is_short;
        total_out_q <= total_q + COUNT_W'(seg);
        last_q      <= seg_last;
      end
    end
  end

  assign slot_o           = slot_q;
  assign hit_o            = hit_q;
  assign chunk_base_o     = base_q;
  assign skip_o           = skip_q;
  assign segment_length_o = seg_q;
  assign short_read_o     = short_q;
  assign total_read_o     = total_out_q;
  assign last_o           = last_q;

endmodule

@@ src/lru_chunk_read_cache.sv @@
// LRU chunk read cache top level: controller and datapath with assertion checks.
// Depends on lrucc_pkg, lrucc_ctrl and lrucc_datapath.
//
// A read request is taken when the block is idle and split into one segment
// per touched chunk, each looked up among eight fully associative slots with
// LRU replacement. Each segment gets its tag compare, LRU update and length
// arithmetic in one step; a request is loaded and then stepped once per
// segment, and stepping holds only while the output register is full and stalled.
// The next request is taken in the cycle after the last segment is produced,
// even while that segment still waits in the output register.
module lru_chunk_read_cache import lrucc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ADDR_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ADDR_W-1:0]  request_position_i,
  input  logic [COUNT_W-1:0] request_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               hit_o,
  output logic [ADDR_W-1:0]  chunk_base_o,
  output logic [OFF_W-1:0]   skip_o,
  output logic [FILL_W-1:0]  segment_length_o,
  output logic               short_read_o,
  output logic [COUNT_W-1:0] total_read_o,
  output logic               last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lrucc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lrucc_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .request_position_i (request_position_i),
    .request_count_i    (request_count_i),
    .slot_o             (slot_o),
    .hit_o              (hit_o),
    .chunk_base_o       (chunk_base_o),
    .skip_o             (skip_o),
    .segment_length_o   (segment_length_o),
    .short_read_o       (short_read_o),
    .total_read_o       (total_read_o),
    .last_o             (last_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Input taken again right after a transaction was accepted.");

  a_short_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && short_read_o) |-> last_o)
    else $error("Short segment did not end the request.");

  a_segment_in_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, skip_o} + segment_length_o) <= FILL_W'(CHUNK_BYTES)))
    else $error("Segment runs past the end of its chunk.");

  a_total_covers_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (total_read_o >= COUNT_W'(segment_length_o)))
    else $error("Running total is below the segment length.");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for lru_chunk_read_cache: request stimulus, a segment
// predictor with its own slot table and LRU order, and a per-segment checker.
// Depends on lrucc_pkg and the lru_chunk_read_cache RTL.
module tb_top;
  import lrucc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic [ADDR_W-1:0]  chunk_base;
    logic [OFF_W-1:0]   skip;
    logic [FILL_W-1:0]  segment_length;
    logic               short_read;
    logic [COUNT_W-1:0] total_read;
    logic               last;
  } segment_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ADDR_W-1:0]  request_position_i = '0;
  logic [COUNT_W-1:0] request_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SLOT_W-1:0]  slot_o;
  logic               hit_o;
  logic [ADDR_W-1:0]  chunk_base_o;
  logic [OFF_W-1:0]   skip_o;
  logic [FILL_W-1:0]  segment_length_o;
  logic               short_read_o;
  logic [COUNT_W-1:0] total_read_o;
  logic               last_o;

  segment_t pending_segments[$];

  logic [ADDR_W-1:0] way_tag[SLOT_COUNT];
  logic              way_valid[SLOT_COUNT];
  logic [FILL_W-1:0] way_fill[SLOT_COUNT];
  logic [SLOT_W-1:0] recency[SLOT_COUNT];
  longint unsigned   model_stream_length = 0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned mismatch_count = 0;
  int          burst_left = 1;
  int          max_burst = 8;
  int          max_gap = 4;
  int          stall_pct = 0;
  int          stall_run = 0;
  bit          stall_now = 1'b0;
  int          hold_off_req = 0;
  int          hold_left = 0;

  lru_chunk_read_cache u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .request_position_i (request_position_i),
    .request_count_i    (request_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .slot_o             (slot_o),
    .hit_o              (hit_o),
    .chunk_base_o       (chunk_base_o),
    .skip_o             (skip_o),
    .segment_length_o   (segment_length_o),
    .short_read_o       (short_read_o),
    .total_read_o       (total_read_o),
    .last_o             (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_chunk_read_cache regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_now = ($urandom_range(0, 99) < stall_pct);
        stall_run = $urandom_range(1, 6);
      end
      stall_run = stall_run - 1;
      out_stall_i <= stall_now;
    end
  end

  always @(posedge clk_i) begin
    segment_t got;
    segment_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{slot_o, hit_o, chunk_base_o, skip_o, segment_length_o,
              short_read_o, total_read_o, last_o};
      if (pending_segments.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected segment: slot=%0d base=%h skip=%h len=%0d",
                   got.slot, got.chunk_base, got.skip, got.segment_length);
      end else begin
        want = pending_segments.pop_front();
        if (got !== want) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"segment mismatch: expected slot=%0d hit=%0d base=%h skip=%h ",
                      "len=%0d short=%0d total=%0d last=%0d, got slot=%0d hit=%0d ",
                      "base=%h skip=%h len=%0d short=%0d total=%0d last=%0d"},
                     want.slot, want.hit, want.chunk_base, want.skip,
                     want.segment_length, want.short_read, want.total_read, want.last,
                     got.slot, got.hit, got.chunk_base, got.skip,
                     got.segment_length, got.short_read, got.total_read, got.last);
        end
      end
    end
  end

  task automatic reset_cache_model();
    int i;
    for (i = 0; i < SLOT_COUNT; i++) begin
      way_tag[i] = '0;
      way_valid[i] = 1'b0;
      way_fill[i] = '0;
      recency[i] = SLOT_W'(i);
    end
    model_stream_length = 0;
  endtask

  task automatic promote(input int p);
    logic [SLOT_W-1:0] s;
    int i;
    s = recency[p];
    for (i = p; i > 0; i--)
      recency[i] = recency[i-1];
    recency[0] = s;
  endtask

  task automatic plan_segments(input logic [ADDR_W-1:0] pos_in,
                               input logic [COUNT_W-1:0] count_in);
    longint unsigned pos, left, total, off, base, fill, wanted, avail, len;
    int hit_pos, n, p;
    logic [SLOT_W-1:0] s;
    bit is_short, is_last, done;
    segment_t seg;
    pos = 64'(pos_in);
    left = 64'(count_in);
    total = 0;
    n = 0;
    if (left > MAX_REQUEST_BYTES)
      left = MAX_REQUEST_BYTES;
    if (left == 0) begin
      off = pos % CHUNK_BYTES;
      seg = '{'0, 1'b0, ADDR_W'(pos - off), OFF_W'(off), '0, 1'b0, '0, 1'b1};
      pending_segments.push_back(seg);
    end else begin
      done = 1'b0;
      while (!done) begin
        off = pos % CHUNK_BYTES;
        base = (pos - off) & 64'hFFFF_FFFF;
        hit_pos = -1;
        for (p = 0; p < SLOT_COUNT; p++) begin
          if (hit_pos < 0 && way_valid[recency[p]] && way_tag[recency[p]] == base)
            hit_pos = p;
        end
        if (hit_pos >= 0) begin
          promote(hit_pos);
          s = recency[0];
        end else begin
          promote(SLOT_COUNT - 1);
          s = recency[0];
          way_tag[s] = ADDR_W'(base);
          way_valid[s] = 1'b1;
          if (base < model_stream_length) begin
            fill = model_stream_length - base;
            if (fill > CHUNK_BYTES)
              fill = CHUNK_BYTES;
          end else begin
            fill = 0;
          end
          way_fill[s] = FILL_W'(fill);
        end
        fill = 64'(way_fill[s]);
        wanted = CHUNK_BYTES - off;
        if (wanted > left)
          wanted = left;
        avail = (fill > off) ? fill - off : 0;
        len = (wanted < avail) ? wanted : avail;
        is_short = wanted > len;
        pos += len;
        total += len;
        left -= len;
        n++;
        is_last = is_short || left == 0 || n >= MAX_SEGS;
        seg = '{s, (hit_pos >= 0), ADDR_W'(base), OFF_W'(off), FILL_W'(len),
                is_short, COUNT_W'(total), is_last};
        pending_segments.push_back(seg);
        done = is_last;
      end
    end
  endtask

  task automatic send_request(input logic [ADDR_W-1:0] pos, input logic [COUNT_W-1:0] cnt);
    in_valid_i <= 1'b1;
    request_position_i <= pos;
    request_count_i <= cnt;
    @(posedge clk_i);
    while (!(in_valid_i && !in_stall_o))
      @(posedge clk_i);
    plan_segments(pos, cnt);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, max_gap)) @(posedge clk_i);
      burst_left = $urandom_range(1, max_burst);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_segments.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_stream_length(input logic [ADDR_W-1:0] value);
    drain_results();
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_stream_length = 64'(value);
  endtask

  task automatic send_random(input logic [ADDR_W-1:0] window);
    logic [ADDR_W-1:0] pos;
    logic [COUNT_W-1:0] cnt;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 8)
      pos = $urandom();
    else
      pos = window + $urandom_range(0, 10 * CHUNK_BYTES);
    kind = $urandom_range(0, 99);
    if (kind < 5)
      cnt = '0;
    else if (kind < 60)
      cnt = COUNT_W'($urandom_range(1, 2 * CHUNK_BYTES));
    else if (kind < 85)
      cnt = COUNT_W'($urandom_range(1, 5 * CHUNK_BYTES));
    else if (kind < 95)
      cnt = COUNT_W'($urandom_range(5 * CHUNK_BYTES, MAX_REQUEST_BYTES));
    else
      cnt = COUNT_W'($urandom_range(MAX_REQUEST_BYTES, (1 << COUNT_W) - 1));
    send_request(pos, cnt);
  endtask

  task automatic test_reset_state();
    send_request(32'hFFFF_FFFF, '0);
    send_request(32'h0001_2345, '0);
    send_request(32'h0000_0000, 17'd10);
    drain_results();
  endtask

  task automatic test_segment_extremes();
    write_stream_length(32'h0002_0000);
    send_request(32'h0000_0000, 17'd4096);
    send_request(32'h0000_0000, 17'd4096);
    send_request(32'h0000_0800, 17'd65536);
    send_request(32'h0000_0100, 17'h1FFFF);
    send_request(32'h0000_0000, 17'd65536);
    drain_results();
  endtask

  task automatic test_short_chunk();
    write_stream_length(32'h0000_1234);
    send_request(32'h0000_1000, 17'd4096);
    write_stream_length(32'h0002_0000);
    send_request(32'h0000_1000, 17'd4096);
    drain_results();
  endtask

  task automatic test_top_of_address();
    write_stream_length(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 17'd1);
    send_request(32'hFFFF_F000, 17'h1FFFF);
    drain_results();
  endtask

  task automatic test_lru_eviction();
    int i;
    write_stream_length(32'h0002_0000);
    for (i = 0; i <= SLOT_COUNT; i++)
      send_request(ADDR_W'(i * CHUNK_BYTES + 3), 17'd1);
    send_request(32'h0000_0000, 17'd2);
    send_request(ADDR_W'(SLOT_COUNT * CHUNK_BYTES), 17'd2);
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [ADDR_W-1:0] lengths[6];
    logic [ADDR_W-1:0] windows[6];
    int ph, i;
    lengths[0] = '0;
    windows[0] = $urandom();
    lengths[1] = 32'd1;
    windows[1] = '0;
    lengths[2] = 6 * CHUNK_BYTES + $urandom_range(0, CHUNK_BYTES - 1);
    windows[2] = '0;
    lengths[3] = 32'hFFFF_FFFF;
    windows[3] = 32'hFFFF_8000;
    lengths[4] = $urandom();
    windows[4] = lengths[4] - 6 * CHUNK_BYTES;
    lengths[5] = 32'h8000_0000;
    windows[5] = 32'h7FFF_C000;
    for (ph = 0; ph < 6; ph++) begin
      write_stream_length(lengths[ph]);
      case (ph % 4)
        0: begin
          stall_pct = 0;
          max_burst = 40;
        end
        1: begin
          stall_pct = 20;
          max_burst = 10;
        end
        2: begin
          stall_pct = 50;
          max_burst = 4;
        end
        default: begin
          stall_pct = 80;
          max_burst = 12;
        end
      endcase
      for (i = 0; i < 49; i++)
        send_random(windows[ph]);
    end
    drain_results();
  endtask

  task automatic test_output_hold_off();
    int i;
    write_stream_length(32'h0004_0000);
    stall_pct = 10;
    max_burst = 40;
    hold_off_req = 400;
    for (i = 0; i < 15; i++)
      send_random(32'h0000_0000);
    drain_results();
  endtask

  task automatic test_sender_pause();
    int i;
    write_stream_length(32'h0001_8000);
    stall_pct = 30;
    max_burst = 6;
    for (i = 0; i < 10; i++)
      send_random(32'h0000_4000);
    drain_results();
    for (i = 0; i < 10; i++)
      send_random(32'h0000_4000);
    drain_results();
  endtask

  initial begin
    reset_cache_model();
    burst_left = $urandom_range(1, max_burst);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_segment_extremes();
    test_short_chunk();
    test_top_of_address();
    test_lru_eviction();
    test_random_phases();
    test_output_hold_off();
    test_sender_pause();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (pending_segments.size() != 0)
      error_count++;
    if (error_count == 0)
      $display("lru_chunk_read_cache regression: pass");
    else
      $display("lru_chunk_read_cache regression: fail");
    $finish;
  end

endmodule
